[rtl/hcbp_pkg.sv]
// ============================================================================
// hcbp_pkg
// Shared types and constants of the Huffman code bit packer: field widths,
// item kinds, controller states and the command and status bundles that pass
// between the controller and the bit packer.
// ============================================================================
`default_nettype none

package hcbp_pkg;

  // Widths of the word fields on the two channels and of the fill level.
  localparam int KIND_W      = 2;
  localparam int SYMBOL_W    = 8;
  localparam int CODE_WORD_W = 32;
  localparam int CODE_SIZE_W = 6;
  localparam int RAW_VALUE_W = 64;
  localparam int RAW_WIDTH_W = 7;
  localparam int BYTE_W      = 8;
  localparam int FILL_W      = 3;

  // Fill level at which the next bit completes a byte.
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BYTE_W - 1);

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_RAW    = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_FLUSH_BYTE,
    ST_FLUSH_COUNT
  } state_t;

  // Commands from the controller to the bit packer.
  typedef struct packed {
    logic start;
    logic flush_byte;
    logic flush_count;
  } pack_cmd_t;

  // Status from the bit packer to the controller.
  typedef struct packed {
    logic busy;
    logic out_free;
  } pack_stat_t;

endpackage

`default_nettype wire

[rtl/hcbp_if.sv]
// ============================================================================
// hcbp_if
// Valid/ready channels of the Huffman code bit packer: the input item channel
// and the packed byte channel.
// ============================================================================
`default_nettype none

interface hcbp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [hcbp_pkg::KIND_W-1:0]          kind;
  logic [hcbp_pkg::SYMBOL_W-1:0]        symbol;
  logic [hcbp_pkg::CODE_WORD_W-1:0]     code_word;
  logic [hcbp_pkg::CODE_SIZE_W-1:0]     code_size;
  logic [hcbp_pkg::RAW_VALUE_W-1:0]     raw_value;
  logic [hcbp_pkg::RAW_WIDTH_W-1:0]     raw_width;

  modport source (
    output valid, kind, symbol, code_word, code_size, raw_value, raw_width,
    input  ready
  );
  modport sink (
    input  valid, kind, symbol, code_word, code_size, raw_value, raw_width,
    output ready
  );
endinterface

interface hcbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [hcbp_pkg::BYTE_W-1:0]   out_byte;
  logic                          last_of_run;

  modport source (
    output valid, out_byte, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last_of_run,
    output ready
  );
endinterface

`default_nettype wire

[rtl/huffman_code_bit_packer.sv]
// ============================================================================
// huffman_code_bit_packer
// Packs Huffman codes and raw header fields most significant bit first into
// bytes, with a code table loaded word by word.
// ============================================================================
// The block takes one input word at a time and sends bits through a serial
// packer at one bit per cycle, except while a completed byte waits for the
// output register. An encode reads the code table before its code is
// shifted. A byte that is completed while the output register still holds
// an untaken byte holds the packer until the output is taken. Each completed
// byte is sent as soon as it is formed; the last byte that an item causes
// carries last_of_run. Encoding a symbol whose table entry was never loaded
// gives undefined bits.
`default_nettype none

module huffman_code_bit_packer #(
  parameter int MAX_CODE_BITS = 32,
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_RAW_BITS  = 64
) (
  input wire logic   clk,
  input wire logic   rst_n,
  hcbp_in_if.sink    in_ch,
  hcbp_out_if.source out_ch
);

  localparam int VAL_W   = (MAX_RAW_BITS > MAX_CODE_BITS) ? MAX_RAW_BITS : MAX_CODE_BITS;
  localparam int CNT_W   = $clog2(VAL_W + 1);
  localparam int SIZE_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
  localparam int ENTRY_W = SIZE_W + hcbp_pkg::CODE_WORD_W;

  localparam logic [hcbp_pkg::SYMBOL_W:0] SYM_LIMIT =
    (hcbp_pkg::SYMBOL_W + 1)'(SYMBOL_COUNT);
  localparam logic [hcbp_pkg::CODE_SIZE_W:0] CODE_LIMIT =
    (hcbp_pkg::CODE_SIZE_W + 1)'(MAX_CODE_BITS);
  localparam logic [hcbp_pkg::RAW_WIDTH_W-1:0] RAW_LIMIT =
    hcbp_pkg::RAW_WIDTH_W'(MAX_RAW_BITS);

  hcbp_pkg::state_t     state_r, state_nxt;
  hcbp_pkg::kind_t      kind;
  hcbp_pkg::pack_cmd_t  cmd;
  hcbp_pkg::pack_stat_t stat;

  logic                                accept;
  logic                                sym_ok;
  logic [SIZE_W-1:0]                   load_size;
  logic [CNT_W-1:0]                    raw_cnt;
  logic [VAL_W-1:0]                    raw_val;
  logic                                tbl_we;
  logic                                tbl_re;
  logic [ENTRY_W-1:0]                  tbl_rdata;
  logic [SIZE_W-1:0]                   rd_size;
  logic [VAL_W+hcbp_pkg::CODE_WORD_W-1:0] code_ext;
  logic [VAL_W-1:0]                    start_val;
  logic [CNT_W-1:0]                    start_cnt;

  // Input word decode.
  assign in_ch.ready = (state_r == hcbp_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign kind        = hcbp_pkg::kind_t'(in_ch.kind);
  assign sym_ok      = ({1'b0, in_ch.symbol} < SYM_LIMIT);

  // Code length and raw width saturation.
  assign load_size = ({1'b0, in_ch.code_size} > CODE_LIMIT) ?
                     SIZE_W'(MAX_CODE_BITS) : SIZE_W'(in_ch.code_size);
  assign raw_cnt   = (in_ch.raw_width > RAW_LIMIT) ?
                     CNT_W'(MAX_RAW_BITS) : CNT_W'(in_ch.raw_width);
  assign raw_val   = in_ch.raw_value[VAL_W-1:0];

  // Code table access.
  assign tbl_we = accept && (kind == hcbp_pkg::KIND_LOAD) && sym_ok;
  assign tbl_re = accept && (kind == hcbp_pkg::KIND_ENCODE) && sym_ok;

  hcbp_code_table #(
    .DEPTH  (SYMBOL_COUNT),
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_W)
  ) u_code_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (in_ch.symbol[ADDR_W-1:0]),
    .wr_data ({load_size, in_ch.code_word}),
    .rd_en   (tbl_re),
    .rd_addr (in_ch.symbol[ADDR_W-1:0]),
    .rd_data (tbl_rdata)
  );

  // Table entry widened to the packer value width; bits above the code word
  // are zero.
  assign rd_size  = tbl_rdata[ENTRY_W-1:hcbp_pkg::CODE_WORD_W];
  assign code_ext = {{VAL_W{1'b0}}, tbl_rdata[hcbp_pkg::CODE_WORD_W-1:0]};

  // The packer starts from the table entry after a read, else from the raw field.
  assign start_val = (state_r == hcbp_pkg::ST_READ) ? code_ext[VAL_W-1:0] : raw_val;
  assign start_cnt = (state_r == hcbp_pkg::ST_READ) ? CNT_W'(rd_size) : raw_cnt;

  // Controller state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hcbp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Controller next state and packer commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      hcbp_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            hcbp_pkg::KIND_LOAD: begin
              state_nxt = hcbp_pkg::ST_IDLE;
            end
            hcbp_pkg::KIND_ENCODE: begin
              if (sym_ok) begin
                state_nxt = hcbp_pkg::ST_READ;
              end
            end
            hcbp_pkg::KIND_RAW: begin
              cmd.start = 1'b1;
              state_nxt = hcbp_pkg::ST_SHIFT;
            end
            hcbp_pkg::KIND_FLUSH: begin
              state_nxt = hcbp_pkg::ST_FLUSH_BYTE;
            end
            default: begin
              state_nxt = hcbp_pkg::ST_IDLE;
            end
          endcase
        end
      end
      hcbp_pkg::ST_READ: begin
        cmd.start = 1'b1;
        state_nxt = hcbp_pkg::ST_SHIFT;
      end
      hcbp_pkg::ST_SHIFT: begin
        if (!stat.busy) begin
          state_nxt = hcbp_pkg::ST_IDLE;
        end
      end
      hcbp_pkg::ST_FLUSH_BYTE: begin
        cmd.flush_byte = 1'b1;
        if (stat.out_free) begin
          state_nxt = hcbp_pkg::ST_FLUSH_COUNT;
        end
      end
      hcbp_pkg::ST_FLUSH_COUNT: begin
        cmd.flush_count = 1'b1;
        if (stat.out_free) begin
          state_nxt = hcbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hcbp_pkg::ST_IDLE;
      end
    endcase
  end

  // Serial bit packer and output register.
  hcbp_bit_packer #(
    .VAL_W (VAL_W),
    .CNT_W (CNT_W)
  ) u_bit_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .start_val (start_val),
    .start_cnt (start_cnt),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last_of_run)
  );

endmodule

`default_nettype wire

[rtl/hcbp_code_table.sv]
// ============================================================================
// hcbp_code_table
// Code table memory: one write port and one read port with registered read
// data. Each entry holds a code length and a code word.
// ============================================================================
`default_nettype none

module hcbp_code_table #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 38
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/hcbp_bit_packer.sv]
// ============================================================================
// hcbp_bit_packer
// Serial bit packer: sends the bits of a loaded value most significant first
// into the pending byte, one bit per cycle unless a completed byte waits for
// the output register; each completed byte and the flush words go to it.
// ============================================================================
`default_nettype none

module hcbp_bit_packer #(
  parameter int VAL_W = 64,
  parameter int CNT_W = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hcbp_pkg::pack_cmd_t           cmd,
  input  wire logic [VAL_W-1:0]              start_val,
  input  wire logic [CNT_W-1:0]              start_cnt,
  output      hcbp_pkg::pack_stat_t          stat,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
  output      logic                          out_last
);

  localparam int IDX_W = $clog2(VAL_W);

  logic [VAL_W-1:0]                val_r, val_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [hcbp_pkg::BYTE_W-1:0]     pend_r, pend_nxt;
  logic [hcbp_pkg::FILL_W-1:0]     fill_r, fill_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [hcbp_pkg::BYTE_W-1:0]     out_byte_r, out_byte_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            busy;
  logic                            out_free;
  logic [CNT_W-1:0]                cnt_m1;
  logic                            cur_bit;
  logic [hcbp_pkg::BYTE_W-1:0]     merged;
  logic                            byte_done;
  logic                            step;

  // Current bit and the pending byte with that bit placed after the fill.
  assign busy      = (cnt_r != '0);
  assign out_free  = !out_valid_r || out_ready;
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign cur_bit   = val_r[cnt_m1[IDX_W-1:0]];
  assign merged    = pend_r | ({cur_bit, {(hcbp_pkg::BYTE_W-1){1'b0}}} >> fill_r);
  assign byte_done = (fill_r == hcbp_pkg::FILL_LAST);

  // A bit that completes a byte waits until the output register is free.
  assign step = busy && (!byte_done || out_free);

  // Next state of the shift, pending byte and output register.
  always_comb begin
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (cmd.start) begin
      val_nxt = start_val;
      cnt_nxt = start_cnt;
    end else if (step) begin
      cnt_nxt = cnt_m1;
      if (byte_done) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = merged;
        out_last_nxt  = (cnt_m1 < CNT_W'(hcbp_pkg::BYTE_W));
        pend_nxt      = '0;
        fill_nxt      = '0;
      end else begin
        pend_nxt = merged;
        fill_nxt = fill_r + hcbp_pkg::FILL_W'(1);
      end
    end else if (cmd.flush_byte && out_free) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = pend_r;
      out_last_nxt  = 1'b0;
    end else if (cmd.flush_count && out_free) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = hcbp_pkg::BYTE_W'(fill_r);
      out_last_nxt  = 1'b1;
      pend_nxt      = '0;
      fill_nxt      = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign stat.busy     = busy;
  assign stat.out_free = out_free;
  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire
